### rtl/triangle_raster_depth_test_macros.svh
// Assertion macros shared by the triangle rasterizer RTL.
`ifndef TRIANGLE_RASTER_DEPTH_TEST_MACROS_SVH
`define TRIANGLE_RASTER_DEPTH_TEST_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication checked on every rising clock edge outside reset.
`define TRDT_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication checked on every rising clock edge outside reset.
`define TRDT_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define TRDT_ASSERT_IMP(label, clk, rst, ante, cons, msg)
`define TRDT_ASSERT_NXT(label, clk, rst, ante, cons, msg)
`endif
`endif

### rtl/trdt_pkg.sv
// Shared types and constants of the triangle rasterizer with depth test.
package trdt_pkg;

   localparam int DEF_MAX_WIDTH  = 512;
   localparam int DEF_MAX_HEIGHT = 512;

   localparam int FRAME_REG_W = 10;
   localparam int CSR_ADDR_W  = 1;
   localparam logic [CSR_ADDR_W-1:0] CSR_FRAME_WIDTH  = 1'b0;
   localparam logic [CSR_ADDR_W-1:0] CSR_FRAME_HEIGHT = 1'b1;

   localparam logic KIND_LOAD = 1'b0;
   localparam logic KIND_STEP = 1'b1;

   localparam logic [1:0] SLOT_A = 2'd0;
   localparam logic [1:0] SLOT_B = 2'd1;
   localparam logic [1:0] SLOT_C = 2'd2;

   localparam int VTX_W    = 16;
   localparam int RGB_W    = 24;
   localparam int INV_Z_W  = 16;
   localparam int PIX_W    = 9;
   localparam int AREA_W   = 35;   // signed area of Q12.4 vertices
   localparam int MANT_W   = 26;
   localparam int SHIFT_W  = 6;
   localparam int WEIGHT_W = 25;   // Q1.24 weight capped at one
   localparam int BB_W     = 14;   // signed box corner before clamping

   localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 25'h100_0000;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_AREA_MUL,
      ST_AREA_SUB,
      ST_NORM,
      ST_DIV,
      ST_EDGE_MUL,
      ST_EDGE_SUB,
      ST_WEIGHT_MUL,
      ST_WEIGHT_SHIFT,
      ST_BLEND_MUL,
      ST_RESOLVE
   } state_type;

endpackage

### rtl/trdt_req_if.sv
// Item channel into the rasterizer: vertex loads and scan steps.
interface trdt_req_if;
   import trdt_pkg::*;
   logic                       valid;
   logic                       ready;
   logic                       kind;
   logic [1:0]                 vertex_slot;
   logic signed [VTX_W-1:0]    vertex_x;
   logic signed [VTX_W-1:0]    vertex_y;
   logic [INV_Z_W-1:0]         vertex_inv_z;
   logic [RGB_W-1:0]           vertex_rgb;

   modport source (output valid, kind, vertex_slot, vertex_x, vertex_y, vertex_inv_z,
                   vertex_rgb, input ready);
   modport sink   (input valid, kind, vertex_slot, vertex_x, vertex_y, vertex_inv_z,
                   vertex_rgb, output ready);
endinterface

### rtl/trdt_rsp_if.sv
// Result channel out of the rasterizer: one beat per scan step.
interface trdt_rsp_if;
   import trdt_pkg::*;
   logic                 valid;
   logic                 ready;
   logic                 wrote;
   logic [PIX_W-1:0]     pixel_x;
   logic [PIX_W-1:0]     pixel_y;
   logic [RGB_W-1:0]     pixel_rgb;
   logic [INV_Z_W-1:0]   pixel_inv_z;
   logic                 walk_done;

   modport source (output valid, wrote, pixel_x, pixel_y, pixel_rgb, pixel_inv_z,
                   walk_done, input ready);
   modport sink   (input valid, wrote, pixel_x, pixel_y, pixel_rgb, pixel_inv_z,
                   walk_done, output ready);
endinterface

### rtl/trdt_csr_if.sv
// Register write channel of the rasterizer.
interface trdt_csr_if;
   import trdt_pkg::*;
   logic                    valid;
   logic                    ready;
   logic [CSR_ADDR_W-1:0]   addr;
   logic [FRAME_REG_W-1:0]  wdata;

   modport source (output valid, addr, wdata, input ready);
   modport sink   (input valid, addr, wdata, output ready);
endinterface

### rtl/triangle_raster_depth_test.sv
// Edge-function triangle rasterizer with an inverse-depth buffer in block memory.
//
//  channel | dir | beat carries
//  --------+-----+--------------------------------------------------------------
//  req_ch  | in  | kind, vertex_slot, vertex_x, vertex_y, vertex_inv_z, vertex_rgb
//  rsp_ch  | out | wrote, pixel_x, pixel_y, pixel_rgb, pixel_inv_z, walk_done
//  csr_ch  | in  | addr (0 frame_width, 1 frame_height), wdata
//
// A scan step runs from its beat through edge multiply, edge subtract with the depth
// read, weight multiply, weight shift, blend multiply and resolve with the depth
// write-back; a step with no walk running goes straight to resolve.
// A load of vertex C holds off the next beat while area, leading-one search and the
// 26-step reciprocal division run; a degenerate triangle or empty box skips the last two.
// After reset the depth memory is swept to zero, all MAX_WIDTH * MAX_HEIGHT entries
// (262144 by default), with req_ch.ready low; register writes are always taken.
// A result waiting on rsp_ch holds the block in its last step until it is taken.
`include "triangle_raster_depth_test_macros.svh"

module triangle_raster_depth_test #(
   parameter int MAX_WIDTH  = trdt_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = trdt_pkg::DEF_MAX_HEIGHT
) (
   input logic        clock,
   input logic        reset,
   trdt_req_if.sink   req_ch,
   trdt_rsp_if.source rsp_ch,
   trdt_csr_if.sink   csr_ch
);
   import trdt_pkg::*;

   localparam int MAX_DIM  = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
   localparam int CW       = $clog2(MAX_DIM + 1);
   localparam int DEPTH    = MAX_WIDTH * MAX_HEIGHT;
   localparam int AW       = $clog2(DEPTH);
   localparam int PW       = CW + 4;
   localparam int DW       = ((PW > VTX_W) ? PW : VTX_W) + 2;
   localparam int VD_W     = VTX_W + 1;
   localparam int EW       = VD_W + DW + 1;
   localparam int RW       = AREA_W + 2;
   localparam int PP_W     = 17 + MANT_W;
   localparam int WF_W     = PP_W + 17;
   localparam int ZP_W     = WEIGHT_W + INV_Z_W;
   localparam int CP_W     = WEIGHT_W + 8;
   localparam logic [AW-1:0]     CLR_LAST = AW'(DEPTH - 1);
   localparam logic [4:0]        DIV_LAST = 5'(MANT_W - 1);
   localparam logic [SHIFT_W-1:0] NORM_TOP = SHIFT_W'(AREA_W - 2);

   // Control state.
   state_type state_ff, state_in;
   logic [AW-1:0] clr_cnt_ff;
   logic [FRAME_REG_W-1:0] fw_ff, fh_ff;
   logic walk_ff;
   logic rsp_valid_ff;

   // Triangle state.
   logic signed [VTX_W-1:0] vx_ff [3];
   logic signed [VTX_W-1:0] vy_ff [3];
   logic [INV_Z_W-1:0]      vz_ff [3];
   logic [RGB_W-1:0]        vc_ff [3];
   logic [MANT_W-1:0]       recip_m_ff;
   logic [SHIFT_W-1:0]      recip_n_ff;
   logic [CW-1:0] box_x0_ff, box_x1_ff, box_y0_ff, box_y1_ff;
   logic [CW-1:0] pos_x_ff, pos_y_ff;

   // Setup datapath.
   logic signed [2*VD_W-1:0] ap0_ff, ap1_ff;
   logic signed [BB_W-1:0]   bx0_ff, bx1_ff, by0_ff, by1_ff;
   logic signed [AREA_W-1:0] area_ff;
   logic [SHIFT_W-1:0]       norm_cnt_ff, n_ff;
   logic [RW-1:0]            rem_ff;
   logic [MANT_W-1:0]        q_ff;
   logic [4:0]               div_cnt_ff;

   // Pixel datapath.
   logic signed [EW-2:0] pm1_ff [3];
   logic signed [EW-2:0] pm2_ff [3];
   logic signed [EW-1:0] e_ff [3];
   logic                 inside_ff;
   logic                 idle_ff;
   logic [AW-1:0]        idx_ff;
   logic [INV_Z_W-1:0]   rd_ff;
   logic [PP_W-1:0]      wlo_ff [3];
   logic [PP_W-1:0]      whi_ff [3];
   logic [WEIGHT_W-1:0]  w_ff [3];
   logic [ZP_W-1:0]      zp_ff [3];
   logic [CP_W-1:0]      cp_ff [3][3];

   // Result register.
   logic                 rsp_wrote_ff, rsp_done_ff;
   logic [PIX_W-1:0]     rsp_x_ff, rsp_y_ff;
   logic [RGB_W-1:0]     rsp_rgb_ff;
   logic [INV_Z_W-1:0]   rsp_z_ff;

   logic [INV_Z_W-1:0] depth_mem [DEPTH];

   // Combinational signals.
   logic req_fire, req_ready, slot_free, rsp_load;
   logic [CW-1:0] eff_w, eff_h;
   logic signed [BB_W-1:0] eff_w_s, eff_h_s;
   logic signed [VTX_W-1:0] lo_x, hi_x, lo_y, hi_y;
   logic signed [BB_W-1:0] fl_x, fl_y, ce_x, ce_y, cl_x0, cl_y0, cl_x1, cl_y1;
   logic signed [VD_W-1:0] dbx, dby, dcx, dcy;
   logic signed [AREA_W-1:0] area_calc;
   logic box_ok;
   logic [RW-1:0] div_diff, div_next;
   logic div_ge;
   logic signed [DW-1:0] px_s, py_s;
   logic [2*CW-1:0] idx_calc;
   logic signed [EW-2:0] pm1_c [3];
   logic signed [EW-2:0] pm2_c [3];
   logic [WEIGHT_W-1:0] w_c [3];
   logic [ZP_W+1:0] z_sum;
   logic [INV_Z_W-1:0] z_sat;
   logic [CP_W+1:0] c_sum [3];
   logic [7:0] c_sat [3];
   logic pix_write;
   logic [CW:0] x_inc, y_inc;
   logic last_row, last_col;
   logic mem_we;
   logic [AW-1:0] mem_waddr;
   logic [INV_Z_W-1:0] mem_wdata;
   logic [31:0] x_wide, y_wide;

   // Frame size in use, clamped to the memory's geometry.
   always_comb begin
      eff_w = ({22'b0, fw_ff} < MAX_WIDTH) ? CW'(fw_ff) : CW'(MAX_WIDTH);
      eff_h = ({22'b0, fh_ff} < MAX_HEIGHT) ? CW'(fh_ff) : CW'(MAX_HEIGHT);
      eff_w_s = BB_W'(eff_w);
      eff_h_s = BB_W'(eff_h);
   end

   // Next-state logic.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (clr_cnt_ff == CLR_LAST) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_ch.valid) begin
               if (req_ch.kind == KIND_STEP) begin
                  state_in = walk_ff ? ST_EDGE_MUL : ST_RESOLVE;
               end else if (req_ch.vertex_slot == SLOT_C) begin
                  state_in = ST_AREA_MUL;
               end
            end
         end
         ST_AREA_MUL:     state_in = ST_AREA_SUB;
         ST_AREA_SUB:     state_in = (area_calc > 0 && box_ok) ? ST_NORM : ST_IDLE;
         ST_NORM: begin
            if (area_ff[norm_cnt_ff]) state_in = ST_DIV;
         end
         ST_DIV: begin
            if (div_cnt_ff == DIV_LAST) state_in = ST_IDLE;
         end
         ST_EDGE_MUL:     state_in = ST_EDGE_SUB;
         ST_EDGE_SUB:     state_in = ST_WEIGHT_MUL;
         ST_WEIGHT_MUL:   state_in = ST_WEIGHT_SHIFT;
         ST_WEIGHT_SHIFT: state_in = ST_BLEND_MUL;
         ST_BLEND_MUL:    state_in = ST_RESOLVE;
         ST_RESOLVE: begin
            if (slot_free) state_in = ST_IDLE;
         end
         default:         state_in = ST_IDLE;
      endcase
   end

   // Handshake outputs of the sequencer.
   always_comb begin
      req_ready = (state_ff == ST_IDLE);
      slot_free = !rsp_valid_ff || rsp_ch.ready;
      rsp_load  = (state_ff == ST_RESOLVE) && slot_free;
   end

   assign req_ch.ready = req_ready;
   assign req_fire     = req_ch.valid && req_ready;
   assign csr_ch.ready = 1'b1;

   // Bounding box: floor of the minimum and ceiling of the maximum, clamped.
   // The ceiling adds 15 before the shift, so it needs one bit above the vertex.
   always_comb begin
      lo_x = vx_ff[0];
      hi_x = vx_ff[0];
      lo_y = vy_ff[0];
      hi_y = vy_ff[0];
      for (int i = 1; i < 3; i++) begin
         if (vx_ff[i] < lo_x) lo_x = vx_ff[i];
         if (vx_ff[i] > hi_x) hi_x = vx_ff[i];
         if (vy_ff[i] < lo_y) lo_y = vy_ff[i];
         if (vy_ff[i] > hi_y) hi_y = vy_ff[i];
      end
      fl_x = BB_W'(lo_x >>> 4);
      fl_y = BB_W'(lo_y >>> 4);
      ce_x = BB_W'(((VTX_W+1)'(hi_x) + (VTX_W+1)'(15)) >>> 4);
      ce_y = BB_W'(((VTX_W+1)'(hi_y) + (VTX_W+1)'(15)) >>> 4);
      cl_x0 = (fl_x < 0) ? '0 : fl_x;
      cl_y0 = (fl_y < 0) ? '0 : fl_y;
      cl_x1 = (ce_x > eff_w_s) ? eff_w_s : ce_x;
      cl_y1 = (ce_y > eff_h_s) ? eff_h_s : ce_y;
      dbx = VD_W'(vx_ff[1]) - VD_W'(vx_ff[0]);
      dby = VD_W'(vy_ff[1]) - VD_W'(vy_ff[0]);
      dcx = VD_W'(vx_ff[2]) - VD_W'(vx_ff[0]);
      dcy = VD_W'(vy_ff[2]) - VD_W'(vy_ff[0]);
      area_calc = AREA_W'(ap0_ff) - AREA_W'(ap1_ff);
      box_ok = (bx1_ff > bx0_ff) && (by1_ff > by0_ff);
   end

   // One step of the restoring division 2^(n+24) / area.
   always_comb begin
      div_diff = rem_ff - RW'(unsigned'(area_ff));
      div_ge   = !div_diff[RW-1];
      div_next = div_ge ? div_diff : rem_ff;
   end

   // Edge functions at the current pixel, one product pair per edge.
   always_comb begin
      px_s = DW'({pos_x_ff, 4'b0000});
      py_s = DW'({pos_y_ff, 4'b0000});
      idx_calc = (2*CW)'(pos_y_ff) * (2*CW)'(eff_w) + (2*CW)'(pos_x_ff);
   end

   for (genvar k = 0; k < 3; k++) begin : g_edge
      // Edge k is (B,C), (C,A), (A,B), so its weight belongs to vertex k.
      localparam int IA = (k == 0) ? 1 : ((k == 1) ? 2 : 0);
      localparam int IB = (k == 0) ? 2 : ((k == 1) ? 0 : 1);
      logic signed [VD_W-1:0] ex, ey;
      logic signed [DW-1:0]   qx, qy;
      logic [WF_W-1:0]        wfull, wsh;
      always_comb begin
         ex = VD_W'(vx_ff[IB]) - VD_W'(vx_ff[IA]);
         ey = VD_W'(vy_ff[IB]) - VD_W'(vy_ff[IA]);
         qx = px_s - DW'(vx_ff[IA]);
         qy = py_s - DW'(vy_ff[IA]);
         pm1_c[k] = ex * qy;
         pm2_c[k] = ey * qx;
         wfull = (WF_W'(whi_ff[k]) << 17) + WF_W'(wlo_ff[k]);
         wsh   = wfull >> recip_n_ff;
         w_c[k] = (wsh > WF_W'(WEIGHT_ONE)) ? WEIGHT_ONE : wsh[WEIGHT_W-1:0];
      end
   end

   // Blend sums, truncation and saturation, depth compare.
   always_comb begin
      z_sum = (ZP_W+2)'(zp_ff[0]) + (ZP_W+2)'(zp_ff[1]) + (ZP_W+2)'(zp_ff[2]);
      z_sat = ((z_sum >> 24) > (ZP_W+2)'(16'hFFFF)) ? 16'hFFFF : z_sum[24 +: INV_Z_W];
      for (int c = 0; c < 3; c++) begin
         c_sum[c] = (CP_W+2)'(cp_ff[c][0]) + (CP_W+2)'(cp_ff[c][1])
                  + (CP_W+2)'(cp_ff[c][2]);
         c_sat[c] = ((c_sum[c] >> 24) > (CP_W+2)'(8'hFF)) ? 8'hFF : c_sum[c][24 +: 8];
      end
      pix_write = !idle_ff && inside_ff && (z_sat > rd_ff);
      x_inc = (CW+1)'(pos_x_ff) + 1'b1;
      y_inc = (CW+1)'(pos_y_ff) + 1'b1;
      last_row = (y_inc >= (CW+1)'(box_y1_ff));
      last_col = (x_inc >= (CW+1)'(box_x1_ff));
      x_wide = 32'(pos_x_ff);
      y_wide = 32'(pos_y_ff);
   end

   // Depth memory write port: the clearing sweep or the resolved pixel.
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = idx_ff;
      mem_wdata = z_sat;
      if (state_ff == ST_CLEAR) begin
         mem_we    = 1'b1;
         mem_waddr = clr_cnt_ff;
         mem_wdata = '0;
      end else if (rsp_load && pix_write) begin
         mem_we = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) depth_mem[mem_waddr] <= mem_wdata;
      if (state_ff == ST_EDGE_SUB) rd_ff <= depth_mem[idx_ff];
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_cnt_ff   <= '0;
         fw_ff        <= FRAME_REG_W'(512);
         fh_ff        <= FRAME_REG_W'(512);
         walk_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < 3; i++) begin
            vx_ff[i] <= '0;
            vy_ff[i] <= '0;
            vz_ff[i] <= '0;
            vc_ff[i] <= '0;
         end
         recip_m_ff <= '0;
         recip_n_ff <= '0;
         box_x0_ff  <= '0;
         box_x1_ff  <= '0;
         box_y0_ff  <= '0;
         box_y1_ff  <= '0;
         pos_x_ff   <= '0;
         pos_y_ff   <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_CLEAR) clr_cnt_ff <= clr_cnt_ff + 1'b1;

         if (csr_ch.valid) begin
            if (csr_ch.addr == CSR_FRAME_WIDTH) fw_ff <= csr_ch.wdata;
            if (csr_ch.addr == CSR_FRAME_HEIGHT) fh_ff <= csr_ch.wdata;
         end

         // A vertex load writes its slot; slot C ends the running walk until its setup arms a new one.
         if (req_fire && req_ch.kind == KIND_LOAD && req_ch.vertex_slot != 2'd3) begin
            vx_ff[req_ch.vertex_slot] <= req_ch.vertex_x;
            vy_ff[req_ch.vertex_slot] <= req_ch.vertex_y;
            vz_ff[req_ch.vertex_slot] <= req_ch.vertex_inv_z;
            vc_ff[req_ch.vertex_slot] <= req_ch.vertex_rgb;
            if (req_ch.vertex_slot == SLOT_C) walk_ff <= 1'b0;
         end

         if (state_ff == ST_AREA_SUB && area_calc > 0 && box_ok) begin
            box_x0_ff <= CW'(bx0_ff);
            box_x1_ff <= CW'(bx1_ff);
            box_y0_ff <= CW'(by0_ff);
            box_y1_ff <= CW'(by1_ff);
            pos_x_ff  <= CW'(bx0_ff);
            pos_y_ff  <= CW'(by0_ff);
         end

         if (state_ff == ST_DIV && div_cnt_ff == DIV_LAST) begin
            recip_m_ff <= {q_ff[MANT_W-2:0], div_ge};
            recip_n_ff <= n_ff;
            walk_ff    <= 1'b1;
         end

         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
            if (!idle_ff) begin
               // y is the inner loop; the walk ends after the box's last column.
               if (!last_row) begin
                  pos_y_ff <= CW'(y_inc);
               end else begin
                  pos_y_ff <= box_y0_ff;
                  pos_x_ff <= CW'(x_inc);
                  if (last_col) walk_ff <= 1'b0;
               end
            end
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      if (req_fire) idle_ff <= !walk_ff;

      if (state_ff == ST_AREA_MUL) begin
         ap0_ff <= dbx * dcy;
         ap1_ff <= dby * dcx;
         bx0_ff <= cl_x0;
         by0_ff <= cl_y0;
         bx1_ff <= cl_x1;
         by1_ff <= cl_y1;
      end

      if (state_ff == ST_AREA_SUB) begin
         area_ff     <= area_calc;
         norm_cnt_ff <= NORM_TOP;
      end

      // Leading-one search, one bit per cycle from the top.
      if (state_ff == ST_NORM) begin
         norm_cnt_ff <= norm_cnt_ff - 1'b1;
         n_ff        <= norm_cnt_ff + 1'b1;
         rem_ff      <= RW'(1) << norm_cnt_ff;
         q_ff        <= '0;
         div_cnt_ff  <= '0;
      end

      if (state_ff == ST_DIV) begin
         rem_ff     <= div_next << 1;
         q_ff       <= {q_ff[MANT_W-2:0], div_ge};
         div_cnt_ff <= div_cnt_ff + 1'b1;
      end

      if (state_ff == ST_EDGE_MUL) begin
         idx_ff <= AW'(idx_calc);
         for (int k = 0; k < 3; k++) begin
            pm1_ff[k] <= pm1_c[k];
            pm2_ff[k] <= pm2_c[k];
         end
      end

      if (state_ff == ST_EDGE_SUB) begin
         for (int k = 0; k < 3; k++) e_ff[k] <= EW'(pm1_ff[k]) - EW'(pm2_ff[k]);
      end

      // Inside the triangle every edge value is at most the area, below 2^34.
      if (state_ff == ST_WEIGHT_MUL) begin
         inside_ff <= !e_ff[0][EW-1] && !e_ff[1][EW-1] && !e_ff[2][EW-1];
         for (int k = 0; k < 3; k++) begin
            wlo_ff[k] <= PP_W'(e_ff[k][16:0]) * PP_W'(recip_m_ff);
            whi_ff[k] <= PP_W'(e_ff[k][33:17]) * PP_W'(recip_m_ff);
         end
      end

      if (state_ff == ST_WEIGHT_SHIFT) begin
         for (int k = 0; k < 3; k++) w_ff[k] <= w_c[k];
      end

      if (state_ff == ST_BLEND_MUL) begin
         for (int k = 0; k < 3; k++) begin
            zp_ff[k] <= ZP_W'(w_ff[k]) * ZP_W'(vz_ff[k]);
            for (int c = 0; c < 3; c++) begin
               cp_ff[c][k] <= CP_W'(w_ff[k]) * CP_W'(vc_ff[k][16 - 8*c +: 8]);
            end
         end
      end

      if (rsp_load) begin
         rsp_wrote_ff <= pix_write;
         rsp_x_ff     <= idle_ff ? '0 : x_wide[PIX_W-1:0];
         rsp_y_ff     <= idle_ff ? '0 : y_wide[PIX_W-1:0];
         rsp_rgb_ff   <= pix_write ? {c_sat[0], c_sat[1], c_sat[2]} : '0;
         rsp_z_ff     <= pix_write ? z_sat : '0;
         rsp_done_ff  <= idle_ff || (last_row && last_col);
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.wrote       = rsp_wrote_ff;
   assign rsp_ch.pixel_x     = rsp_x_ff;
   assign rsp_ch.pixel_y     = rsp_y_ff;
   assign rsp_ch.pixel_rgb   = rsp_rgb_ff;
   assign rsp_ch.pixel_inv_z = rsp_z_ff;
   assign rsp_ch.walk_done   = rsp_done_ff;

   // A written pixel has won the depth test against a store that is never below zero.
   `TRDT_ASSERT_IMP(a_wrote_nonzero, clock, reset, rsp_valid_ff && rsp_wrote_ff,
      rsp_z_ff != '0, "written pixel carries zero inverse depth")
   // The walk position always lies inside the current box.
   `TRDT_ASSERT_IMP(a_pos_in_box, clock, reset, walk_ff,
      pos_x_ff < box_x1_ff && pos_y_ff < box_y1_ff, "walk position outside box")
   // The last division step arms the walk.
   `TRDT_ASSERT_NXT(a_div_arms_walk, clock, reset,
      state_ff == ST_DIV && div_cnt_ff == DIV_LAST, walk_ff, "walk not started")

endmodule
